/* sv/epipolar_point_transfer_residual_macros.svh */
// assertion macros for the epipolar point transfer residual checker
`ifndef EPIPOLAR_POINT_TRANSFER_RESIDUAL_MACROS_SVH
`define EPIPOLAR_POINT_TRANSFER_RESIDUAL_MACROS_SVH

// same-cycle implication
`define EPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ept: same-cycle check failed");

// next-cycle implication
`define EPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ept: next-cycle check failed");

`endif

/* sv/ept_pkg.sv */
// shared types and constants for the epipolar point transfer residual block
package ept_pkg;

  localparam int STORE_DEPTH = 18;

  typedef enum logic [1:0] {
    CFG_FOCAL_X,
    CFG_FOCAL_Y,
    CFG_CENTER_X,
    CFG_CENTER_Y
  } cfg_reg_t;

  typedef enum logic {
    REQ_LOAD,
    REQ_TRIPLET
  } req_t;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

  typedef struct packed {
    logic              degenerate;
    logic signed [31:0] residual_y;
    logic signed [31:0] residual_x;
  } res_t;

endpackage

/* sv/ept_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
module ept_div #(
  parameter int NW = 57,
  parameter int QW = 32,
  parameter int DW = 31,
  parameter int PW = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_div,
  input  logic [PW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_side
);
  localparam int WW = DW + QW;

  logic [WW-1:0] w_r    [QW+1];
  logic [WW-1:0] w_nxt  [QW];
  logic [DW-1:0] div_r  [QW+1];
  logic [PW-1:0] side_r [QW+1];
  logic [QW:0]   vld_r;
  logic [WW-1:0] w_init;

  // upper part of the numerator starts as the partial remainder
  assign w_init = {{(WW-NW){1'b0}}, in_num};

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] d;
    assign t = w_r[k][WW-1:QW-1];
    assign d = t - {1'b0, div_r[k]};
    assign w_nxt[k] = d[DW] ? {t[DW-1:0], w_r[k][QW-2:0], 1'b0}
                            : {d[DW-1:0], w_r[k][QW-2:0], 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_r[0]    <= w_init;
      div_r[0]  <= in_div;
      side_r[0] <= in_side;
      for (int k = 0; k < QW; k++) begin
        w_r[k+1]    <= w_nxt[k];
        div_r[k+1]  <= div_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = w_r[QW][QW-1:0];
  assign out_side  = side_r[QW];

endmodule

/* sv/ept_obuf.sv */
// two-entry result buffer between the datapath and the master side
module ept_obuf (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ept_pkg::res_t push_data,
  output logic          ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ept_pkg::res_t out_data
);
  import ept_pkg::*;

  res_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       pop;

  assign ready     = ~cnt_r[1];
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid & out_ready;
  assign cnt_nxt   = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

/* sv/epipolar_point_transfer_residual.sv */
// Epipolar point transfer residual: takes coefficient loads and point triplets on one
// stream, one transfer per cycle while the output buffer has room, and returns one
// result per triplet in order, through two restoring dividers (normalization and
// projection) that resolve one quotient bit per stage; a two-entry output buffer keeps
// the input side moving while a result waits. Loads write the matrix store when they
// reach the matrix stage, so they order correctly against triplets in flight. The user
// must write intrinsics only while the block is idle; the block does not enforce this.
module epipolar_point_transfer_residual (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // coef_index, coef_value, first_x, first_y, second_x, second_y, query_x, query_y
  input  logic [231:0] in_tdata,
  input  logic [0:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // residual_x, residual_y
  output logic [0:0]   out_tuser,  // degenerate
  input  logic         cfg_we,
  input  logic [1:0]   cfg_addr,
  input  logic [30:0]  cfg_wdata
);
  import ept_pkg::*;

  typedef struct packed {
    logic               trip;
    logic [4:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } item_t;

  typedef struct packed {
    logic        ovf;
    logic        neg;
    logic [56:0] num;
  } norm_in_t;

  typedef struct packed {
    logic               deg;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
  } proj_t;

  localparam int ITEM_W = $bits(item_t);
  localparam int PROJ_W = $bits(proj_t);

  function automatic norm_in_t prep_norm(input logic signed [31:0] p,
                                         input logic [30:0] c, input logic [30:0] f);
    logic [32:0] u;
    logic [32:0] mag;
    norm_in_t    r;
    u     = {p[31], p} - {2'b00, c};
    mag   = u[32] ? (33'd0 - u) : u;
    r.neg = u[32];
    r.ovf = ({6'b0, mag} >= {f, 8'b0});
    r.num = r.ovf ? 57'd0 : {mag, 24'b0};
    return r;
  endfunction

  function automatic logic signed [31:0] sat_norm(input logic ovf, input logic neg,
                                                  input logic [31:0] q);
    logic signed [31:0] r;
    if (ovf) r = neg ? SAT_MIN : SAT_MAX;
    else if (neg) r = (q > 32'h80000000) ? SAT_MIN : $signed(32'd0 - q);
    else r = q[31] ? SAT_MAX : $signed(q);
    return r;
  endfunction

  function automatic logic signed [31:0] sat38(input logic signed [37:0] v);
    logic signed [31:0] r;
    if (v > 38'(SAT_MAX)) r = SAT_MAX;
    else if (v < 38'(SAT_MIN)) r = SAT_MIN;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] finish(input logic ovf, input logic neg,
                                                input logic [33:0] quo, input logic [30:0] c,
                                                input logic signed [31:0] obs);
    logic signed [35:0] qs;
    logic signed [37:0] sum;
    logic signed [31:0] r;
    qs  = neg ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    sum = $signed({7'b0, c}) + 38'(qs) - 38'(obs);
    if (ovf) r = neg ? SAT_MIN : SAT_MAX;
    else r = sat38(sum);
    return r;
  endfunction

  // configuration
  logic [30:0] focal_x_r, focal_y_r, center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 31'd34310586;
      focal_y_r  <= 31'd34712388;
      center_x_r <= 31'd20594360;
      center_y_r <= 31'd15571026;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FOCAL_X:  focal_x_r  <= cfg_wdata;
        CFG_FOCAL_Y:  focal_y_r  <= cfg_wdata;
        CFG_CENTER_X: center_x_r <= cfg_wdata;
        CFG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic en;
  logic in_fire;
  assign in_tready = en;
  assign in_fire   = in_tvalid & en;

  // input stage
  logic               s0_vld_r;
  item_t              s0_item_r;
  logic signed [31:0] s0_pt_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) s0_vld_r <= 1'b0;
    else if (en) s0_vld_r <= in_fire;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item_r.trip <= (req_t'(in_tuser[0]) == REQ_TRIPLET);
      s0_item_r.idx  <= in_tdata[4:0];
      s0_item_r.val  <= in_tdata[36:5];
      s0_pt_r[0]     <= in_tdata[68:37];
      s0_pt_r[1]     <= in_tdata[100:69];
      s0_pt_r[2]     <= in_tdata[132:101];
      s0_pt_r[3]     <= in_tdata[164:133];
      s0_item_r.qx   <= in_tdata[196:165];
      s0_item_r.qy   <= in_tdata[228:197];
    end
  end

  // normalization dividers
  norm_in_t          nrm [4];
  logic [31:0]       dn_quo [4];
  logic [1:0]        dn_flag [4];
  logic [ITEM_W+1:0] dn_side0;
  logic              dn_vld;
  logic [30:0]       nrm_c [4];
  logic [30:0]       nrm_f [4];

  assign nrm_c[0] = center_x_r;
  assign nrm_c[1] = center_y_r;
  assign nrm_c[2] = center_x_r;
  assign nrm_c[3] = center_y_r;
  assign nrm_f[0] = focal_x_r;
  assign nrm_f[1] = focal_y_r;
  assign nrm_f[2] = focal_x_r;
  assign nrm_f[3] = focal_y_r;

  for (genvar i = 0; i < 4; i++) begin : g_nrm
    assign nrm[i] = prep_norm(s0_pt_r[i], nrm_c[i], nrm_f[i]);
  end

  ept_div #(.NW(57), .QW(32), .DW(31), .PW(ITEM_W + 2)) u_div_n0 (
    .clk, .rst_n, .en,
    .in_valid (s0_vld_r),
    .in_num   (nrm[0].num),
    .in_div   (nrm_f[0]),
    .in_side  ({nrm[0].ovf, nrm[0].neg, s0_item_r}),
    .out_valid(dn_vld),
    .out_quo  (dn_quo[0]),
    .out_side (dn_side0)
  );
  assign dn_flag[0] = dn_side0[ITEM_W+1:ITEM_W];

  for (genvar i = 1; i < 4; i++) begin : g_div_n
    ept_div #(.NW(57), .QW(32), .DW(31), .PW(2)) u_div_n (
      .clk, .rst_n, .en,
      .in_valid (s0_vld_r),
      .in_num   (nrm[i].num),
      .in_div   (nrm_f[i]),
      .in_side  ({nrm[i].ovf, nrm[i].neg}),
      .out_valid(),
      .out_quo  (dn_quo[i]),
      .out_side (dn_flag[i])
    );
  end

  // normalized coordinates, store write for loads
  logic               n_vld_r;
  item_t              n_item_r;
  logic signed [31:0] n_r [4];
  logic signed [31:0] store_r [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) n_vld_r <= 1'b0;
    else if (en) n_vld_r <= dn_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_item_r <= item_t'(dn_side0[ITEM_W-1:0]);
      for (int i = 0; i < 4; i++) begin
        n_r[i] <= sat_norm(dn_flag[i][1], dn_flag[i][0], dn_quo[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && n_vld_r && !n_item_r.trip && (n_item_r.idx < 5'(STORE_DEPTH))) begin
      store_r[n_item_r.idx] <= n_item_r.val;
    end
  end

  // matrix products
  logic               m_vld_r;
  logic signed [31:0] m_qx_r, m_qy_r;
  logic signed [63:0] pa_r [6];
  logic signed [63:0] pb_r [6];
  logic signed [27:0] c_r  [6];
  logic signed [63:0] pa_nxt [6];
  logic signed [63:0] pb_nxt [6];

  for (genvar v = 0; v < 2; v++) begin : g_view
    for (genvar i = 0; i < 3; i++) begin : g_row
      assign pa_nxt[3*v+i] = store_r[9*v+3*i] * n_r[2*v];
      assign pb_nxt[3*v+i] = store_r[9*v+3*i+1] * n_r[2*v+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) m_vld_r <= 1'b0;
    else if (en) m_vld_r <= n_vld_r & n_item_r.trip;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_qx_r <= n_item_r.qx;
      m_qy_r <= n_item_r.qy;
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          pa_r[3*v+i] <= pa_nxt[3*v+i];
          pb_r[3*v+i] <= pb_nxt[3*v+i];
          c_r[3*v+i]  <= store_r[9*v+3*i+2][31:4];
        end
      end
    end
  end

  // line coefficients
  logic               s_vld_r;
  logic signed [31:0] s_qx_r, s_qy_r;
  logic signed [31:0] ln_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) s_vld_r <= 1'b0;
    else if (en) s_vld_r <= m_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_qx_r <= m_qx_r;
      s_qy_r <= m_qy_r;
      for (int j = 0; j < 6; j++) begin
        ln_r[j] <= sat38(38'($signed(pa_r[j][63:28])) + 38'($signed(pb_r[j][63:28]))
                         + 38'(c_r[j]));
      end
    end
  end

  // cross products of the two lines
  logic               x_vld_r, x_deg_r;
  logic signed [31:0] x_qx_r, x_qy_r;
  logic signed [63:0] x_p_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) x_vld_r <= 1'b0;
    else if (en) x_vld_r <= s_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_qx_r   <= s_qx_r;
      x_qy_r   <= s_qy_r;
      x_deg_r  <= (ln_r[1] == 32'sd0) || (ln_r[4] == 32'sd0);
      x_p_r[0] <= ln_r[1] * ln_r[5];
      x_p_r[1] <= ln_r[2] * ln_r[4];
      x_p_r[2] <= ln_r[2] * ln_r[3];
      x_p_r[3] <= ln_r[0] * ln_r[5];
      x_p_r[4] <= ln_r[0] * ln_r[4];
      x_p_r[5] <= ln_r[1] * ln_r[3];
    end
  end

  // homogeneous intersection
  logic               q_vld_r, q_deg_r;
  logic signed [31:0] q_qx_r, q_qy_r;
  logic signed [40:0] q_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) q_vld_r <= 1'b0;
    else if (en) q_vld_r <= x_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_qx_r  <= x_qx_r;
      q_qy_r  <= x_qy_r;
      q_deg_r <= x_deg_r;
      for (int i = 0; i < 3; i++) begin
        q_r[i] <= 41'($signed(x_p_r[2*i][63:24])) - 41'($signed(x_p_r[2*i+1][63:24]));
      end
    end
  end

  // least common shift that brings all three into 32 bits
  logic [3:0]         sh_nxt;
  logic               h_vld_r, h_deg_r;
  logic signed [31:0] h_qx_r, h_qy_r;
  logic signed [40:0] h_q_r [3];
  logic [3:0]         h_sh_r;

  always_comb begin
    logic               ok;
    logic signed [40:0] hi;
    sh_nxt = 4'd9;
    for (int s = 9; s >= 0; s--) begin
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
        hi = q_r[i] >>> (31 + s);
        if (!((hi == '0) || (hi == '1))) ok = 1'b0;
      end
      if (ok) sh_nxt = 4'(s);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else if (en) h_vld_r <= q_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_qx_r  <= q_qx_r;
      h_qy_r  <= q_qy_r;
      h_deg_r <= q_deg_r;
      h_sh_r  <= sh_nxt;
      for (int i = 0; i < 3; i++) h_q_r[i] <= q_r[i];
    end
  end

  logic               w_vld_r, w_deg_r;
  logic signed [31:0] w_qx_r, w_qy_r;
  logic signed [31:0] w_h_r [3];
  logic signed [40:0] w_sh [3];

  for (genvar i = 0; i < 3; i++) begin : g_shift
    assign w_sh[i] = h_q_r[i] >>> h_sh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) w_vld_r <= 1'b0;
    else if (en) w_vld_r <= h_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w_qx_r  <= h_qx_r;
      w_qy_r  <= h_qy_r;
      w_deg_r <= h_deg_r;
      for (int i = 0; i < 3; i++) w_h_r[i] <= w_sh[i][31:0];
    end
  end

  // scale by focal lengths
  logic               p_vld_r;
  proj_t              p_side_r;
  logic signed [63:0] p_px_r, p_py_r;
  logic signed [31:0] p_qw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else if (en) p_vld_r <= w_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_side_r.qx  <= w_qx_r;
      p_side_r.qy  <= w_qy_r;
      p_side_r.deg <= w_deg_r || (w_h_r[2] == 32'sd0);
      p_px_r       <= $signed({1'b0, focal_x_r}) * w_h_r[0];
      p_py_r       <= $signed({1'b0, focal_y_r}) * w_h_r[1];
      p_qw_r       <= w_h_r[2];
    end
  end

  // projection dividers
  logic [31:0] qw_mag;
  logic [63:0] px_abs, py_abs;
  logic        rx_ovf, ry_ovf, rx_neg, ry_neg;
  logic [62:0] rx_num, ry_num;

  assign qw_mag = p_qw_r[31] ? (32'd0 - p_qw_r) : p_qw_r;
  assign px_abs = p_px_r[63] ? (64'd0 - p_px_r) : p_px_r;
  assign py_abs = p_py_r[63] ? (64'd0 - p_py_r) : p_py_r;
  assign rx_ovf = ({3'b0, px_abs[62:0]} >= {qw_mag, 34'b0});
  assign ry_ovf = ({3'b0, py_abs[62:0]} >= {qw_mag, 34'b0});
  assign rx_neg = p_px_r[63] ^ p_qw_r[31];
  assign ry_neg = p_py_r[63] ^ p_qw_r[31];
  assign rx_num = rx_ovf ? 63'd0 : px_abs[62:0];
  assign ry_num = ry_ovf ? 63'd0 : py_abs[62:0];

  logic              dr_vld;
  logic [33:0]       drx_quo, dry_quo;
  logic [PROJ_W+1:0] drx_side;
  logic [1:0]        dry_flag;
  proj_t             dr_proj;

  ept_div #(.NW(63), .QW(34), .DW(32), .PW(PROJ_W + 2)) u_div_rx (
    .clk, .rst_n, .en,
    .in_valid (p_vld_r),
    .in_num   (rx_num),
    .in_div   (qw_mag),
    .in_side  ({rx_ovf, rx_neg, p_side_r}),
    .out_valid(dr_vld),
    .out_quo  (drx_quo),
    .out_side (drx_side)
  );

  ept_div #(.NW(63), .QW(34), .DW(32), .PW(2)) u_div_ry (
    .clk, .rst_n, .en,
    .in_valid (p_vld_r),
    .in_num   (ry_num),
    .in_div   (qw_mag),
    .in_side  ({ry_ovf, ry_neg}),
    .out_valid(),
    .out_quo  (dry_quo),
    .out_side (dry_flag)
  );

  // residuals
  res_t res;
  res_t out_res;
  logic degen;

  assign dr_proj = proj_t'(drx_side[PROJ_W-1:0]);
  assign degen   = dr_proj.deg || (focal_x_r == 31'd0) || (focal_y_r == 31'd0);

  always_comb begin
    res.degenerate = degen;
    if (degen) begin
      res.residual_x = SAT_MAX;
      res.residual_y = SAT_MAX;
    end else begin
      res.residual_x = finish(drx_side[PROJ_W+1], drx_side[PROJ_W], drx_quo,
                              center_x_r, dr_proj.qx);
      res.residual_y = finish(dry_flag[1], dry_flag[0], dry_quo, center_y_r, dr_proj.qy);
    end
  end

  ept_obuf u_obuf (
    .clk, .rst_n,
    .push     (en & dr_vld),
    .push_data(res),
    .ready    (en),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_data (out_res)
  );

  assign out_tdata = {out_res.residual_y, out_res.residual_x};
  assign out_tuser = out_res.degenerate;

endmodule

/* sv/ept_checker.sv */
// port-level checker for the epipolar point transfer residual block
module ept_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import ept_pkg::*;
  `include "epipolar_point_transfer_residual_macros.svh"

  // input side only backs up behind a waiting result
  `EPT_ASSERT_IMP(a_stall_has_result, clk, rst_n, !in_tready, out_tvalid)
  // degenerate results carry saturated residuals
  `EPT_ASSERT_IMP(a_degen_sat, clk, rst_n, out_tvalid && out_tuser[0],
                  out_tdata == {SAT_MAX, SAT_MAX})
  `EPT_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                  out_tvalid && $stable(out_tdata) && $stable(out_tuser))

endmodule

bind epipolar_point_transfer_residual ept_checker u_ept_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

/* sim/tb_epipolar_point_transfer_residual.sv */
// self-checking testbench for the epipolar point transfer residual block
module tb_epipolar_point_transfer_residual;
  import ept_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE = 100;
  localparam longint ONE_Q24 = 64'sd16777216;
  localparam logic signed [31:0] ONE_Q28 = 32'sd268435456;

  typedef struct {
    req_t               kind;
    logic [4:0]         slot;
    logic signed [31:0] coef;
    logic signed [31:0] ax, ay, bx, by, qx, qy;
  } request_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [231:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_addr = '0;
  logic [30:0]  cfg_wdata = '0;

  request_t pending_q[$];
  res_t     residual_q[$];
  request_t cur_req;
  longint   focal_x = 34310586, focal_y = 34712388;
  longint   center_x = 20594360, center_y = 15571026;
  int       coef_store [STORE_DEPTH];
  int       errors = 0;
  int       cycles = 0;
  bit       hold_req = 1'b0;

  epipolar_point_transfer_residual u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit fits32(longint v);
    return v == sat32(v);
  endfunction

  function automatic void epiline(int base, longint px, longint py, output longint m [3]);
    longint n [3];
    longint acc;
    n[0] = sat32(((px - center_x) * ONE_Q24) / focal_x);
    n[1] = sat32(((py - center_y) * ONE_Q24) / focal_y);
    n[2] = ONE_Q24;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += (longint'(coef_store[base + 3 * i + j]) * n[j]) >>> 28;
      m[i] = sat32(acc);
    end
  endfunction

  // returns 1 when the request produces a residual
  function automatic bit transfer_point(request_t r, output res_t res);
    longint l [3], k [3], q [3];
    int     s;
    bit     degen;
    degen = 1'b0;
    if (r.kind == REQ_LOAD) begin
      if (r.slot < STORE_DEPTH) coef_store[r.slot] = r.coef;
      return 1'b0;
    end
    if (focal_x == 0 || focal_y == 0) degen = 1'b1;
    else begin
      epiline(0, longint'(r.ax), longint'(r.ay), l);
      epiline(9, longint'(r.bx), longint'(r.by), k);
      if (l[1] == 0 || k[1] == 0) degen = 1'b1;
    end
    if (!degen) begin
      q[0] = ((l[1] * k[2]) >>> 24) - ((l[2] * k[1]) >>> 24);
      q[1] = ((l[2] * k[0]) >>> 24) - ((l[0] * k[2]) >>> 24);
      q[2] = ((l[0] * k[1]) >>> 24) - ((l[1] * k[0]) >>> 24);
      s = 0;
      while (s < 16 && !(fits32(q[0] >>> s) && fits32(q[1] >>> s) && fits32(q[2] >>> s)))
        s++;
      for (int i = 0; i < 3; i++) q[i] = q[i] >>> s;
      if (q[2] == 0) degen = 1'b1;
    end
    res.degenerate = degen;
    if (degen) begin
      res.residual_x = SAT_MAX;
      res.residual_y = SAT_MAX;
    end else begin
      res.residual_x = 32'(sat32(center_x + (focal_x * q[0]) / q[2] - longint'(r.qx)));
      res.residual_y = 32'(sat32(center_y + (focal_y * q[1]) / q[2] - longint'(r.qy)));
    end
    return 1'b1;
  endfunction

  function automatic void add_request(request_t r);
    pending_q = {pending_q, r};
  endfunction

  // input driver
  int drv_gap = 0;
  bit drv_burst = 1'b0;
  always @(posedge clk) begin
    res_t exp_res;
    bit   offer;
    int   r;
    if (in_tvalid && in_tready && transfer_point(cur_req, exp_res))
      residual_q = {residual_q, exp_res};
    if ($urandom_range(0, 199) == 0) drv_burst = !drv_burst;
    offer = 1'b0;
    if (!rst_n) offer = 1'b0;
    else if (in_tvalid && !in_tready) offer = 1'b1;
    else if (drv_gap > 0) drv_gap--;
    else if (pending_q.size() > 0) begin
      cur_req = pending_q.pop_front();
      offer = 1'b1;
      r = $urandom_range(0, 99);
      if (drv_burst || r < 50) drv_gap = 0;
      else if (r < 92) drv_gap = $urandom_range(1, 3);
      else drv_gap = $urandom_range(10, 40);
    end
    in_tvalid <= offer;
    if (offer) begin
      in_tuser <= cur_req.kind;
      in_tdata <= {3'b000, cur_req.qy, cur_req.qx, cur_req.by, cur_req.bx,
                   cur_req.ay, cur_req.ax, cur_req.coef, cur_req.slot};
    end
  end

  // result monitor
  int  stall = 0;
  bit  hold_seen = 1'b0;
  bit  mon_burst = 1'b0;
  always @(posedge clk) begin
    res_t exp_res;
    int   r;
    if (out_tvalid && out_tready) begin
      if (residual_q.size() == 0) begin
        $display("%0t: unexpected result %h/%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        exp_res = residual_q.pop_front();
        if (out_tdata[31:0] !== exp_res.residual_x) begin
          $display("%0t: residual_x expected %h actual %h", $time,
                   exp_res.residual_x, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[63:32] !== exp_res.residual_y) begin
          $display("%0t: residual_y expected %h actual %h", $time,
                   exp_res.residual_y, out_tdata[63:32]);
          errors++;
        end
        if (out_tuser[0] !== exp_res.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time,
                   exp_res.degenerate, out_tuser[0]);
          errors++;
        end
      end
    end
    if (hold_req && !hold_seen) begin
      hold_seen = 1'b1;
      stall = 400;
    end
    if ($urandom_range(0, 199) == 0) mon_burst = !mon_burst;
    if (stall > 0) begin
      stall--;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (mon_burst || r < 60) out_tready <= 1'b1;
      else begin
        out_tready <= 1'b0;
        if (r < 95) stall = $urandom_range(0, 3);
        else stall = $urandom_range(10, 40);
      end
    end
  end

  function automatic request_t mk_load(logic [4:0] slot, logic signed [31:0] coef);
    request_t r;
    r = '{kind: REQ_LOAD, slot: slot, coef: coef, default: '0};
    return r;
  endfunction

  function automatic request_t mk_triplet(logic signed [31:0] ax, ay, bx, by, qx, qy);
    request_t r;
    r = '{kind: REQ_TRIPLET, slot: 5'($urandom), coef: $urandom,
          ax: ax, ay: ay, bx: bx, by: by, qx: qx, qy: qy};
    return r;
  endfunction

  function automatic logic signed [31:0] pixel();
    return $urandom_range(0, 32'd2000 << 16);
  endfunction

  function automatic request_t rand_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)
      return mk_load(5'($urandom_range(0, 17)), $urandom_range(0, 1 << 29) - (1 << 28));
    if (r < 7) return mk_load(5'($urandom_range(0, 17)), $urandom);
    if (r < 8) return mk_load(5'($urandom_range(18, 31)), $urandom);
    if (r < 20)
      return mk_triplet($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return mk_triplet(pixel(), pixel(), pixel(), pixel(), pixel(), pixel());
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [30:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_FOCAL_X:  focal_x = longint'(value);
      CFG_FOCAL_Y:  focal_y = longint'(value);
      CFG_CENTER_X: center_x = longint'(value);
      CFG_CENTER_Y: center_y = longint'(value);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_tvalid || residual_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_intrinsics(logic [30:0] fx, fy, cx, cy);
    write_reg(CFG_FOCAL_X, fx);
    write_reg(CFG_FOCAL_Y, fy);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
  endtask

  initial begin
    logic signed [31:0] first_mat [9];
    logic signed [31:0] second_mat [9];
    first_mat = '{0, -ONE_Q28, 53687091, ONE_Q28, 0, 0, -53687091, 80530637, 0};
    second_mat = '{26843546, -ONE_Q28, 80530637, ONE_Q28, 53687091, -53687091,
                   -80530637, 53687091, 26843546};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: matrix loads, ignored slot, extremes, degenerate line
    for (int i = 0; i < 9; i++) add_request(mk_load(5'(i), first_mat[i]));
    for (int i = 0; i < 9; i++) add_request(mk_load(5'(9 + i), second_mat[i]));
    add_request(mk_load(5'd31, 32'sh7fffffff));
    add_request(mk_triplet(640 << 16, 480 << 16, 700 << 16, 300 << 16,
                           500 << 16, 200 << 16));
    add_request(mk_triplet(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX));
    add_request(mk_triplet(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN));
    // first point on the principal column makes its line's second term zero
    add_request(mk_triplet(20594360, 100 << 16, 700 << 16, 300 << 16, 0, 0));
    add_request(mk_load(5'd0, SAT_MAX));
    add_request(mk_load(5'd9, SAT_MIN));
    add_request(mk_triplet(900 << 16, 50 << 16, 10 << 16, 800 << 16,
                           SAT_MIN, SAT_MAX));
    for (int i = 0; i < 150; i++) add_request(rand_request());
    drain();

    set_intrinsics(31'd65536, 31'd65536, 31'd0, 31'd0);
    for (int i = 0; i < 180; i++) add_request(rand_request());
    drain();

    // long output hold-off while the input keeps offering
    set_intrinsics(31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
    hold_req = 1'b1;
    for (int i = 0; i < 180; i++) add_request(rand_request());
    drain();

    set_intrinsics(31'($urandom_range(500, 2000) << 16), 31'($urandom_range(500, 2000) << 16),
                   31'($urandom_range(0, 1000) << 16), 31'($urandom_range(0, 1000) << 16));
    for (int i = 0; i < 180; i++) add_request(rand_request());
    drain();

    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/ept_pkg.sv
sv/ept_div.sv
sv/ept_obuf.sv
sv/epipolar_point_transfer_residual.sv
sv/ept_checker.sv
sim/tb_epipolar_point_transfer_residual.sv
